[rtl/tmi_pkg.sv]
// shared constants, tanh table and fixed-point helpers for the tanh perceptron
package tmi_pkg;

   localparam int TMI_NUM_INPUTS = 4;
   localparam int TMI_NUM_HIDDEN = 8;
   localparam int Q_W = 16;
   localparam int ACC_W = 40;
   localparam int TANH_HALF = 128;
   localparam int TH_W = 14;

   localparam logic TMI_OP_PARAM   = 1'b0;
   localparam logic TMI_OP_FEATURE = 1'b1;

   typedef logic signed [Q_W-1:0] q12_type;
   typedef logic signed [ACC_W-1:0] acc_type;

   // rounded Q32 product of two Q32 values below 2^44
   function automatic logic [63:0] tmi_mul_q32(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] ah;
      logic [63:0] al;
      logic [63:0] bh;
      logic [63:0] bl;
      logic [63:0] low;
      ah = a >> 32;
      al = {32'd0, a[31:0]};
      bh = b >> 32;
      bl = {32'd0, b[31:0]};
      low = (al * bl + (64'd1 << 31)) >> 32;
      return ((ah * bh) << 32) + ah * bl + al * bh + low;
   endfunction

   // unsigned long division, used only while building constant tables
   function automatic logic [63:0] tmi_udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[63:0], n[k]};
         if (r >= {1'b0, d}) begin
            r = r - {1'b0, d};
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // positive half of the tanh table, entry m at the midpoint (2m+1)/64
   function automatic logic [TANH_HALF*16-1:0] tmi_build_tanh();
      logic [TANH_HALF*16-1:0] lut;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] big;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] v;
      logic [63:0] pw [8];
      int unsigned e;
      lut = '0;
      term = 64'd1 << 60;
      sum = term;
      for (int n = 1; n <= 14; n++) begin
         term = tmi_udiv64(term, 64'(32 * n));
         sum = sum + term;
      end
      pw[0] = (sum + (64'd1 << 27)) >> 28;
      for (int b = 1; b < 8; b++) begin
         pw[b] = tmi_mul_q32(pw[b-1], pw[b-1]);
      end
      for (int m = 0; m < TANH_HALF; m++) begin
         e = 32'(2 * m + 1);
         big = 64'd1 << 32;
         for (int b = 0; b < 8; b++) begin
            if (e[b]) begin
               big = tmi_mul_q32(big, pw[b]);
            end
         end
         num = big - (64'd1 << 32);
         den = big + (64'd1 << 32);
         v = tmi_udiv64(64'd8192 * num + den, 64'd2 * den);
         lut[m*16 +: 16] = v[15:0];
      end
      return lut;
   endfunction

   localparam logic [TANH_HALF*16-1:0] TANH_LUT = tmi_build_tanh();

   // q16.24 sum to saturated q4.12, nearest with ties upward
   function automatic q12_type tmi_to_q12(input acc_type acc);
      acc_type r;
      r = (acc + ACC_W'(2048)) >>> 12;
      if (r > ACC_W'(32767)) begin
         return 16'sh7fff;
      end else if (r < -ACC_W'(32768)) begin
         return 16'sh8000;
      end
      return r[Q_W-1:0];
   endfunction

   // table index floor(h/128)+128, clamped
   function automatic logic [7:0] tmi_tanh_index(input q12_type h);
      if (h < -16'sd16384) begin
         return 8'd0;
      end else if (h > 16'sd16383) begin
         return 8'd255;
      end
      return {~h[14], h[13:7]};
   endfunction

endpackage

[rtl/tmi_ram.sv]
// generic single-port-write ram with registered read
module tmi_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/tanh_mlp_inference_top.sv]
// top level of the tanh perceptron: weight and feature memories, sequencer and mac pipeline
// parameter loads and features without last leave busy low
// a feature with last starts an inference: busy is high until it drops with the result strobe
// the weight memory read port sets the pace: one stored word per cycle
// reset clears the sequencer and the result strobe; memory contents are undefined until written
module tanh_mlp_inference_top
   import tmi_pkg::*;
#(
   parameter int NUM_INPUTS = TMI_NUM_INPUTS,
   parameter int NUM_HIDDEN = TMI_NUM_HIDDEN
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [9:0]  req_address,
   input  logic signed [15:0] req_value,
   input  logic        req_last,
   output logic        rsp_valid,
   output logic        rsp_jump,
   output logic signed [15:0] rsp_decision_sum
);

   localparam int HB_BASE = NUM_INPUTS * NUM_HIDDEN;
   localparam int WO_BASE = HB_BASE + NUM_HIDDEN;
   localparam int BO_ADDR = WO_BASE + NUM_HIDDEN;
   localparam int STORE_DEPTH = BO_ADDR + 1;
   localparam int WA_W = $clog2(STORE_DEPTH);
   localparam int FA_W = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
   localparam int ST_W = $clog2(NUM_INPUTS + 2);
   localparam int HJ_W = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_OB    = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DRAIN = 2'd3;

   localparam logic [2:0] TAG_NONE = 3'd0;
   localparam logic [2:0] TAG_OB   = 3'd1;
   localparam logic [2:0] TAG_HB   = 3'd2;
   localparam logic [2:0] TAG_HW   = 3'd3;
   localparam logic [2:0] TAG_WO   = 3'd4;

   logic [1:0]      state_ff, state_in;
   logic [ST_W-1:0] step_ff, step_in;
   logic [HJ_W-1:0] hid_ff, hid_in;
   logic [WA_W-1:0] hw_ptr_ff, hw_ptr_in;

   logic            accept;
   logic [31:0]     req_addr32;
   logic            w_wr_en, f_wr_en;
   logic [WA_W-1:0] w_rd_addr;
   logic [FA_W-1:0] f_rd_addr;
   logic [ST_W-1:0] step_m1;
   q12_type         w_rd, f_rd;
   logic [2:0]      tag_in;
   logic            tag_last_in;

   logic [2:0]      tag1_ff;
   logic            last1_ff;
   logic signed [31:0] prod_ff;
   logic            pv_ff;
   acc_type         hacc_ff;
   q12_type         wo_ff, wo2_ff, wo3_ff;
   logic            rnd_v_ff, rnd_l_ff;
   logic [7:0]      idx_ff;
   logic            lut_v_ff, lut_l_ff;
   logic signed [TH_W-1:0] th_ff, th_in;
   logic            mul_v_ff, mul_l_ff;
   logic signed [TH_W+Q_W-1:0] oprod_ff;
   logic            oa_v_ff, oa_l_ff;
   acc_type         oacc_ff;
   logic            fin_ff;
   logic            rsp_valid_ff;
   q12_type         rsp_sum_ff;
   q12_type         out_q;
   logic [6:0]      lut_sel;
   logic [15:0]     lut_word;

   assign busy = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign req_addr32 = 32'(req_address);
   assign w_wr_en = accept && (req_op == TMI_OP_PARAM) && (req_addr32 < 32'(STORE_DEPTH));
   assign f_wr_en = accept && (req_op == TMI_OP_FEATURE) && (req_addr32 < 32'(NUM_INPUTS));
   assign step_m1 = step_ff - 1'b1;
   assign f_rd_addr = FA_W'(step_m1);

   tmi_ram #(.WIDTH(Q_W), .DEPTH(STORE_DEPTH)) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (req_addr32[WA_W-1:0]),
      .wr_data (req_value),
      .rd_addr (w_rd_addr),
      .rd_data (w_rd)
   );

   tmi_ram #(.WIDTH(Q_W), .DEPTH(NUM_INPUTS)) u_feature_ram (
      .clock   (clock),
      .wr_en   (f_wr_en),
      .wr_addr (req_addr32[FA_W-1:0]),
      .wr_data (req_value),
      .rd_addr (f_rd_addr),
      .rd_data (f_rd)
   );

   // sequencer: one weight word per cycle
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      hid_in = hid_ff;
      hw_ptr_in = hw_ptr_ff;
      w_rd_addr = WA_W'(BO_ADDR);
      tag_in = TAG_NONE;
      tag_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == TMI_OP_FEATURE) && req_last) begin
               state_in = ST_OB;
            end
         end
         ST_OB: begin
            tag_in = TAG_OB;
            state_in = ST_RUN;
            step_in = '0;
            hid_in = '0;
            hw_ptr_in = '0;
         end
         ST_RUN: begin
            if (step_ff == '0) begin
               w_rd_addr = WA_W'(HB_BASE) + WA_W'(hid_ff);
               tag_in = TAG_HB;
               step_in = step_ff + 1'b1;
            end else if (step_ff == ST_W'(NUM_INPUTS + 1)) begin
               w_rd_addr = WA_W'(WO_BASE) + WA_W'(hid_ff);
               tag_in = TAG_WO;
               tag_last_in = (hid_ff == HJ_W'(NUM_HIDDEN - 1));
               step_in = '0;
               if (hid_ff == HJ_W'(NUM_HIDDEN - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  hid_in = hid_ff + 1'b1;
               end
            end else begin
               w_rd_addr = hw_ptr_ff;
               tag_in = TAG_HW;
               hw_ptr_in = hw_ptr_ff + 1'b1;
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (fin_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      hid_ff <= hid_in;
      hw_ptr_ff <= hw_ptr_in;
   end

   // tanh lookup, negative half by symmetry
   assign lut_sel = idx_ff[7] ? idx_ff[6:0] : ~idx_ff[6:0];
   assign lut_word = TANH_LUT[{lut_sel, 4'b0000} +: 16];
   assign th_in = idx_ff[7] ? $signed(lut_word[TH_W-1:0]) : -$signed(lut_word[TH_W-1:0]);
   assign out_q = tmi_to_q12(oacc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= TAG_NONE;
         pv_ff <= 1'b0;
         rnd_v_ff <= 1'b0;
         lut_v_ff <= 1'b0;
         mul_v_ff <= 1'b0;
         oa_v_ff <= 1'b0;
         fin_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff <= tag_in;
         pv_ff <= (tag1_ff == TAG_HW);
         rnd_v_ff <= (tag1_ff == TAG_WO);
         lut_v_ff <= rnd_v_ff;
         mul_v_ff <= lut_v_ff;
         oa_v_ff <= mul_v_ff;
         fin_ff <= oa_v_ff && oa_l_ff;
         rsp_valid_ff <= fin_ff;
      end
      last1_ff <= tag_last_in;
      rnd_l_ff <= last1_ff;
      lut_l_ff <= rnd_l_ff;
      mul_l_ff <= lut_l_ff;
      oa_l_ff <= mul_l_ff;

      prod_ff <= w_rd * f_rd;
      if (tag1_ff == TAG_HB) begin
         hacc_ff <= $signed({{(ACC_W-Q_W-12){w_rd[Q_W-1]}}, w_rd, 12'b0});
      end else if (pv_ff) begin
         hacc_ff <= hacc_ff + ACC_W'(prod_ff);
      end
      if (tag1_ff == TAG_WO) begin
         wo_ff <= w_rd;
      end

      idx_ff <= tmi_tanh_index(tmi_to_q12(hacc_ff));
      wo2_ff <= wo_ff;
      th_ff <= th_in;
      wo3_ff <= wo2_ff;
      oprod_ff <= th_ff * wo3_ff;

      if (tag1_ff == TAG_OB) begin
         oacc_ff <= $signed({{(ACC_W-Q_W-12){w_rd[Q_W-1]}}, w_rd, 12'b0});
      end else if (oa_v_ff) begin
         oacc_ff <= oacc_ff + ACC_W'(oprod_ff);
      end

      if (fin_ff) begin
         rsp_sum_ff <= out_q;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_decision_sum = rsp_sum_ff;
   assign rsp_jump = !rsp_sum_ff[Q_W-1];

   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_no_bias_accum_clash: assert property (@(posedge clock) disable iff (reset)
      !(pv_ff && (tag1_ff == TAG_HB)))
      else $error("hidden bias load collides with a pending product");

endmodule
